// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the point-line distance checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/spld_pkg.sv =====
// ----------------------------------------------------------------------------
// spld_pkg
// Widths, constants, sideband types and the arctangent table shared by the
// point-line distance pipeline.
// ----------------------------------------------------------------------------
package spld_pkg;

  localparam int COSINE_ITERATIONS_DEF = 24;

  localparam int CW   = 34;
  localparam int PW   = 46;
  localparam int HW   = PW / 2;
  localparam int MW   = 2 * PW;
  localparam int LW   = MW + 1;
  localparam int XW   = MW + 2;
  localparam int RW   = 49;
  localparam int SNW  = 2 * RW;
  localparam int SRW  = 52;
  localparam int DW   = RW + 10;
  localparam int QW   = 33;
  localparam int NUMW = MW;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [29:0] ANGLE_SCALE = 30'd670742542;
  localparam logic [32:0] QUARTER_X3  = 33'd2700000000;
  localparam logic [32:0] HALF_X3     = 33'd5400000000;
  localparam logic [13:0] LON_UM      = 14'd11132;
  localparam logic [13:0] LAT_UM      = 14'd11054;
  localparam logic [9:0]  UM_PER_MM   = 10'd1000;

  typedef struct packed {
    logic signed [32:0] dlon2;
    logic signed [32:0] dlon0;
    logic signed [31:0] dlat2;
    logic signed [31:0] dlat0;
    logic               flip;
  } geo_t;

  typedef struct packed {
    logic signed [XW-1:0] xprod;
    logic                 degen;
  } sq_side_t;

  typedef struct packed {
    logic neg;
    logic degen;
  } dv_side_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [5:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      6'd0:  r = 34'sd843314857;
      6'd1:  r = 34'sd497837829;
      6'd2:  r = 34'sd263043837;
      6'd3:  r = 34'sd133525159;
      6'd4:  r = 34'sd67021687;
      6'd5:  r = 34'sd33543516;
      6'd6:  r = 34'sd16775851;
      6'd7:  r = 34'sd8388437;
      6'd8:  r = 34'sd4194283;
      6'd9:  r = 34'sd2097149;
      6'd10: r = 34'sd1048576;
      6'd11: r = 34'sd524288;
      6'd12: r = 34'sd262144;
      6'd13: r = 34'sd131072;
      6'd14: r = 34'sd65536;
      6'd15: r = 34'sd32768;
      6'd16: r = 34'sd16384;
      6'd17: r = 34'sd8192;
      6'd18: r = 34'sd4096;
      6'd19: r = 34'sd2048;
      6'd20: r = 34'sd1024;
      6'd21: r = 34'sd512;
      6'd22: r = 34'sd256;
      6'd23: r = 34'sd128;
      6'd24: r = 34'sd64;
      6'd25: r = 34'sd32;
      6'd26: r = 34'sd16;
      6'd27: r = 34'sd8;
      6'd28: r = 34'sd4;
      6'd29: r = 34'sd2;
      6'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/spld_mul.sv =====
// ----------------------------------------------------------------------------
// spld_mul
// Two-stage unsigned multiplier built from four registered half-width
// partial products.
// ----------------------------------------------------------------------------
module spld_mul (
  input  logic                   clk,
  input  logic                   en,
  input  logic [spld_pkg::PW-1:0] a,
  input  logic [spld_pkg::PW-1:0] b,
  output logic [spld_pkg::MW-1:0] p
);
  import spld_pkg::*;

  logic [2*HW-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [MW-1:0]   p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= (2*HW)'(a[HW-1:0]) * (2*HW)'(b[HW-1:0]);
      pp01_r <= (2*HW)'(a[HW-1:0]) * (2*HW)'(b[PW-1:HW]);
      pp10_r <= (2*HW)'(a[PW-1:HW]) * (2*HW)'(b[HW-1:0]);
      pp11_r <= (2*HW)'(a[PW-1:HW]) * (2*HW)'(b[PW-1:HW]);
      p_r    <= (MW'(pp11_r) << (2*HW)) + (MW'(pp01_r) << HW) + (MW'(pp10_r) << HW)
                + MW'(pp00_r);
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/spld_cordic.sv =====
// ----------------------------------------------------------------------------
// spld_cordic
// Rotation-mode cosine, one iteration per register stage, Q2.30 angle.
// ----------------------------------------------------------------------------
module spld_cordic #(
  parameter int ITER = spld_pkg::COSINE_ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [spld_pkg::CW-1:0] z_in,
  input  spld_pkg::geo_t                in_side,
  output logic                          out_valid,
  output logic signed [spld_pkg::CW-1:0] x_out,
  output spld_pkg::geo_t                out_side
);
  import spld_pkg::*;

  logic signed [CW-1:0] xs [ITER+1];
  logic signed [CW-1:0] ys [ITER+1];
  logic signed [CW-1:0] zs [ITER+1];
  logic                 vs [ITER+1];
  geo_t                 ss [ITER+1];

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_in;
  assign vs[0] = in_valid;
  assign ss[0] = in_side;

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN_I = atan_q30(6'(i));
    logic signed [CW-1:0] x_r, y_r, z_r, dx, dy;
    logic                 v_r;
    geo_t                 s_r;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          x_r <= xs[i] - dx;
          y_r <= ys[i] + dy;
          z_r <= zs[i] - ATAN_I;
        end else begin
          x_r <= xs[i] + dx;
          y_r <= ys[i] - dy;
          z_r <= zs[i] + ATAN_I;
        end
        s_r <= ss[i];
      end
    end

    assign xs[i+1] = x_r;
    assign ys[i+1] = y_r;
    assign zs[i+1] = z_r;
    assign vs[i+1] = v_r;
    assign ss[i+1] = s_r;
  end

  assign out_valid = vs[ITER];
  assign x_out     = xs[ITER];
  assign out_side  = ss[ITER];

endmodule

// ===== hdl/spld_sqrt.sv =====
// ----------------------------------------------------------------------------
// spld_sqrt
// Floor integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module spld_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [spld_pkg::SNW-1:0] n_in,
  input  spld_pkg::sq_side_t      in_side,
  output logic                    out_valid,
  output logic [spld_pkg::RW-1:0]  root,
  output spld_pkg::sq_side_t      out_side
);
  import spld_pkg::*;

  logic [SNW-1:0] ns [RW+1];
  logic [SRW-1:0] rs [RW+1];
  logic [RW-1:0]  qs [RW+1];
  logic           vs [RW+1];
  sq_side_t       ss [RW+1];

  assign ns[0] = n_in;
  assign rs[0] = '0;
  assign qs[0] = '0;
  assign vs[0] = in_valid;
  assign ss[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SRW+1:0] rem_sh, trial, diff;
    logic           ge;
    logic [SNW-1:0] n_r;
    logic [SRW-1:0] r_r;
    logic [RW-1:0]  q_r;
    logic           v_r;
    sq_side_t       s_r;

    assign rem_sh = {rs[k], ns[k][SNW-1 -: 2]};
    assign trial  = (SRW+2)'({qs[k], 2'b01});
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r <= ge ? diff[SRW-1:0] : rem_sh[SRW-1:0];
        q_r <= {qs[k][RW-2:0], ge};
        n_r <= {ns[k][SNW-3:0], 2'b00};
        s_r <= ss[k];
      end
    end

    assign ns[k+1] = n_r;
    assign rs[k+1] = r_r;
    assign qs[k+1] = q_r;
    assign vs[k+1] = v_r;
    assign ss[k+1] = s_r;
  end

  assign out_valid = vs[RW];
  assign root      = qs[RW];
  assign out_side  = ss[RW];

endmodule

// ===== hdl/spld_div.sv =====
// ----------------------------------------------------------------------------
// spld_div
// Restoring divider, one quotient bit per register stage, with a sticky
// flag for quotients too large for the result range.
// ----------------------------------------------------------------------------
module spld_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [spld_pkg::NUMW-1:0] num_in,
  input  logic [spld_pkg::DW-1:0]   den_in,
  input  spld_pkg::dv_side_t       in_side,
  output logic                     out_valid,
  output logic [spld_pkg::QW-1:0]   quot,
  output logic                     big,
  output logic [spld_pkg::DW-1:0]   rem,
  output logic [spld_pkg::DW-1:0]   den_out,
  output spld_pkg::dv_side_t       out_side
);
  import spld_pkg::*;

  logic [NUMW-1:0] ns [NUMW+1];
  logic [DW-1:0]   ds [NUMW+1];
  logic [DW-1:0]   rs [NUMW+1];
  logic [QW-1:0]   qs [NUMW+1];
  logic            bs [NUMW+1];
  logic            vs [NUMW+1];
  dv_side_t        ss [NUMW+1];

  assign ns[0] = num_in;
  assign ds[0] = den_in;
  assign rs[0] = '0;
  assign qs[0] = '0;
  assign bs[0] = 1'b0;
  assign vs[0] = in_valid;
  assign ss[0] = in_side;

  for (genvar k = 0; k < NUMW; k++) begin : g_stage
    logic [DW:0]     rem_sh, diff;
    logic            ge;
    logic [NUMW-1:0] n_r;
    logic [DW-1:0]   d_r, r_r;
    logic [QW-1:0]   q_r;
    logic            b_r, v_r;
    dv_side_t        s_r;

    assign rem_sh = {rs[k], ns[k][NUMW-1]};
    assign ge     = rem_sh >= {1'b0, ds[k]};
    assign diff   = rem_sh - {1'b0, ds[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        q_r <= {qs[k][QW-2:0], ge};
        b_r <= bs[k] | qs[k][QW-1];
        n_r <= {ns[k][NUMW-2:0], 1'b0};
        d_r <= ds[k];
        s_r <= ss[k];
      end
    end

    assign ns[k+1] = n_r;
    assign ds[k+1] = d_r;
    assign rs[k+1] = r_r;
    assign qs[k+1] = q_r;
    assign bs[k+1] = b_r;
    assign vs[k+1] = v_r;
    assign ss[k+1] = s_r;
  end

  assign out_valid = vs[NUMW];
  assign quot      = qs[NUMW];
  assign big       = bs[NUMW];
  assign rem       = rs[NUMW];
  assign den_out   = ds[NUMW];
  assign out_side  = ss[NUMW];

endmodule

// ===== hdl/signed_point_line_distance.sv =====
// Throughput: one item per cycle while the skid stage is empty; the whole pipeline advances together.
// Pipeline depth is set by the 92-stage quotient, the 49-stage root and one stage per CORDIC step.
// The output register plus a one-entry skid stage hold results while out_ready is low.
// Reset (synchronous, rst_n low) clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// signed_point_line_distance
// Signed perpendicular distance in millimetres from a GPS point to a line
// through two GPS points, using a local flat-earth projection.
// ----------------------------------------------------------------------------
module signed_point_line_distance #(
  parameter int COSINE_ITERATIONS = spld_pkg::COSINE_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_lon,
  input  logic signed [30:0] in_point_lat,
  input  logic signed [31:0] in_line_start_lon,
  input  logic signed [30:0] in_line_start_lat,
  input  logic signed [31:0] in_line_end_lon,
  input  logic signed [30:0] in_line_end_lat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_distance_mm,
  output logic               out_degenerate,
  output logic               out_saturated
);
  import spld_pkg::*;

  logic en;

  // stage A: latitude sum, angle fold, coordinate deltas
  logic signed [32:0] lat_sum_nxt;
  logic [31:0]        lat_abs_nxt, ang_nxt;
  geo_t               geo_nxt;
  logic               a_v_r;
  logic [31:0]        ang_r;
  geo_t               geo_a_r;

  assign lat_sum_nxt = 33'(in_point_lat) + 33'(in_line_start_lat) + 33'(in_line_end_lat);
  assign lat_abs_nxt = lat_sum_nxt[32] ? 32'(-lat_sum_nxt) : 32'(lat_sum_nxt);

  always_comb begin
    geo_nxt.flip  = {1'b0, lat_abs_nxt} > QUARTER_X3;
    geo_nxt.dlon2 = 33'(in_line_end_lon) - 33'(in_line_start_lon);
    geo_nxt.dlon0 = 33'(in_point_lon) - 33'(in_line_start_lon);
    geo_nxt.dlat2 = 32'(in_line_end_lat) - 32'(in_line_start_lat);
    geo_nxt.dlat0 = 32'(in_point_lat) - 32'(in_line_start_lat);
    ang_nxt = geo_nxt.flip ? 32'(HALF_X3 - {1'b0, lat_abs_nxt}) : lat_abs_nxt;
  end

  // stage B: angle scale product; stage C: round to Q2.30
  logic               b_v_r, c_v_r;
  logic [61:0]        prod_r;
  geo_t               geo_b_r, geo_c_r;
  logic [62:0]        rnd_nxt;
  logic signed [CW-1:0] z_c_r;

  assign rnd_nxt = {1'b0, prod_r} + 63'(64'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r   <= ang_nxt;
      geo_a_r <= geo_nxt;
      prod_r  <= 62'(ang_r) * 62'(ANGLE_SCALE);
      geo_b_r <= geo_a_r;
      z_c_r   <= $signed({1'b0, rnd_nxt[62:30]});
      geo_c_r <= geo_b_r;
    end
  end

  logic                 cor_v;
  logic signed [CW-1:0] cor_x;
  geo_t                 cor_geo;

  spld_cordic #(
    .ITER (COSINE_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .z_in      (z_c_r),
    .in_side   (geo_c_r),
    .out_valid (cor_v),
    .x_out     (cor_x),
    .out_side  (cor_geo)
  );

  // P1: clamp cosine, magnitude products
  logic [30:0] cmag_nxt;
  logic        cneg_nxt;
  logic [32:0] dm2_nxt, dm0_nxt;
  logic [31:0] ym2_nxt, ym0_nxt;

  always_comb begin
    if (cor_x < 0) begin
      cmag_nxt = '0;
    end else if (cor_x > $signed({3'b000, ONE_Q30})) begin
      cmag_nxt = ONE_Q30;
    end else begin
      cmag_nxt = cor_x[30:0];
    end
    cneg_nxt = cor_geo.flip && (cmag_nxt != '0);
    dm2_nxt  = cor_geo.dlon2[32] ? 33'(-cor_geo.dlon2) : 33'(cor_geo.dlon2);
    dm0_nxt  = cor_geo.dlon0[32] ? 33'(-cor_geo.dlon0) : 33'(cor_geo.dlon0);
    ym2_nxt  = cor_geo.dlat2[31] ? 32'(-cor_geo.dlat2) : 32'(cor_geo.dlat2);
    ym0_nxt  = cor_geo.dlat0[31] ? 32'(-cor_geo.dlat0) : 32'(cor_geo.dlat0);
  end

  logic          p1_v_r, p2_v_r;
  logic [62:0]   t2_r, t0_r;
  logic [PW-1:0] y2m_p1_r, y0m_p1_r, y2m_r, y0m_r, x2m_r, x0m_r;
  logic          xn2_p1_r, xn0_p1_r, yn2_p1_r, yn0_p1_r;
  logic          xn2_r, xn0_r, yn2_r, yn0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r     <= 63'(dm2_nxt) * 63'(cmag_nxt);
      t0_r     <= 63'(dm0_nxt) * 63'(cmag_nxt);
      y2m_p1_r <= PW'(ym2_nxt) * PW'(LAT_UM);
      y0m_p1_r <= PW'(ym0_nxt) * PW'(LAT_UM);
      xn2_p1_r <= cor_geo.dlon2[32] ^ cneg_nxt;
      xn0_p1_r <= cor_geo.dlon0[32] ^ cneg_nxt;
      yn2_p1_r <= cor_geo.dlat2[31];
      yn0_p1_r <= cor_geo.dlat0[31];
    end
  end

  // P2: scale to micrometres with rounding of the fractional part
  logic [43:0] fr2_nxt, fr0_nxt;

  assign fr2_nxt = 44'(t2_r[29:0]) * 44'(LON_UM) + 44'(64'd1 << 29);
  assign fr0_nxt = 44'(t0_r[29:0]) * 44'(LON_UM) + 44'(64'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      x2m_r <= PW'(t2_r[62:30]) * PW'(LON_UM) + PW'(fr2_nxt[43:30]);
      x0m_r <= PW'(t0_r[62:30]) * PW'(LON_UM) + PW'(fr0_nxt[43:30]);
      y2m_r <= y2m_p1_r;
      y0m_r <= y0m_p1_r;
      xn2_r <= xn2_p1_r;
      xn0_r <= xn0_p1_r;
      yn2_r <= yn2_p1_r;
      yn0_r <= yn0_p1_r;
    end
  end

  // wide products, two stages
  logic [MW-1:0] pxx, pyy, pxy, pyx;

  spld_mul u_mul_xx (.clk(clk), .en(en), .a(x2m_r), .b(x2m_r), .p(pxx));
  spld_mul u_mul_yy (.clk(clk), .en(en), .a(y2m_r), .b(y2m_r), .p(pyy));
  spld_mul u_mul_xy (.clk(clk), .en(en), .a(x2m_r), .b(y0m_r), .p(pxy));
  spld_mul u_mul_yx (.clk(clk), .en(en), .a(y2m_r), .b(x0m_r), .p(pyx));

  logic m1_v_r, m2_v_r, m1_sp_r, m2_sp_r, m1_sq_r, m2_sq_r, m1_dg_r, m2_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= cor_v;
      p2_v_r <= p1_v_r;
      m1_v_r <= p2_v_r;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sp_r <= xn2_r ^ yn0_r;
      m1_sq_r <= !(yn2_r ^ xn0_r);
      m1_dg_r <= (x2m_r == '0) && (y2m_r == '0);
      m2_sp_r <= m1_sp_r;
      m2_sq_r <= m1_sq_r;
      m2_dg_r <= m1_dg_r;
    end
  end

  // P5: squared length and signed cross product
  logic                 p5_v_r;
  logic [LW-1:0]        len2_r;
  sq_side_t             sq_side_r;
  logic signed [XW-1:0] pv_nxt, qv_nxt;

  assign pv_nxt = m2_sp_r ? -$signed(XW'(pxy)) : $signed(XW'(pxy));
  assign qv_nxt = m2_sq_r ? -$signed(XW'(pyx)) : $signed(XW'(pyx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len2_r          <= LW'(pxx) + LW'(pyy);
      sq_side_r.xprod <= pv_nxt + qv_nxt;
      sq_side_r.degen <= m2_dg_r;
    end
  end

  logic          sq_v;
  logic [RW-1:0] sq_root;
  sq_side_t      sq_side;

  spld_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p5_v_r),
    .n_in      (SNW'(len2_r)),
    .in_side   (sq_side_r),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // P6: divisor and numerator magnitude
  logic                 p6_v_r;
  logic [DW-1:0]        den_r;
  logic [NUMW-1:0]      num_r;
  dv_side_t             dv_side_r;
  logic signed [XW-1:0] cabs_nxt;

  assign cabs_nxt = sq_side.xprod[XW-1] ? -sq_side.xprod : sq_side.xprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_v_r <= 1'b0;
    end else if (en) begin
      p6_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r           <= DW'(sq_root) * DW'(UM_PER_MM);
      num_r           <= cabs_nxt[NUMW-1:0];
      dv_side_r.neg   <= sq_side.xprod[XW-1];
      dv_side_r.degen <= sq_side.degen;
    end
  end

  logic          dv_v, dv_big;
  logic [QW-1:0] dv_quot;
  logic [DW-1:0] dv_rem, dv_den;
  dv_side_t      dv_side;

  spld_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p6_v_r),
    .num_in    (num_r),
    .den_in    (den_r),
    .in_side   (dv_side_r),
    .out_valid (dv_v),
    .quot      (dv_quot),
    .big       (dv_big),
    .rem       (dv_rem),
    .den_out   (dv_den),
    .out_side  (dv_side)
  );

  // F: round half away from zero
  logic          f_v_r, f_big_r, f_neg_r, f_dg_r;
  logic [QW:0]   f_mag_r;
  logic          rnd_up_nxt;

  assign rnd_up_nxt = {dv_rem, 1'b0} >= {1'b0, dv_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mag_r <= (QW+1)'(dv_quot) + (QW+1)'(rnd_up_nxt);
      f_big_r <= dv_big;
      f_neg_r <= dv_side.neg;
      f_dg_r  <= dv_side.degen;
    end
  end

  // saturate and sign
  logic signed [31:0] end_dist;
  logic               end_dg, end_sat;

  always_comb begin
    end_dg  = 1'b0;
    end_sat = 1'b0;
    if (f_dg_r) begin
      end_dist = '0;
      end_dg   = 1'b1;
    end else if (!f_neg_r) begin
      if (f_big_r || f_mag_r > (QW+1)'(32'h7FFF_FFFF)) begin
        end_dist = 32'sh7FFF_FFFF;
        end_sat  = 1'b1;
      end else begin
        end_dist = $signed(f_mag_r[31:0]);
      end
    end else begin
      if (f_big_r || f_mag_r > (QW+1)'(32'h8000_0000)) begin
        end_dist = $signed(32'h8000_0000);
        end_sat  = 1'b1;
      end else begin
        end_dist = $signed(32'((QW+1)'(0) - f_mag_r));
      end
    end
  end

  // output register and skid stage
  logic               out_v_r, skid_v_r, pop, push;
  logic signed [31:0] out_dist_r, skid_dist_r;
  logic               out_dg_r, out_sat_r, skid_dg_r, skid_sat_r;

  assign en   = !skid_v_r;
  assign pop  = out_v_r && out_ready;
  assign push = en && f_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || pop) begin
        out_v_r <= skid_v_r || push;
      end
      if (skid_v_r) begin
        if (pop) begin
          skid_v_r <= 1'b0;
        end
      end else if (push && out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_dist_r <= skid_dist_r;
        out_dg_r   <= skid_dg_r;
        out_sat_r  <= skid_sat_r;
      end else begin
        out_dist_r <= end_dist;
        out_dg_r   <= end_dg;
        out_sat_r  <= end_sat;
      end
    end
    if (!skid_v_r) begin
      skid_dist_r <= end_dist;
      skid_dg_r   <= end_dg;
      skid_sat_r  <= end_sat;
    end
  end

  assign in_ready        = en;
  assign out_valid       = out_v_r;
  assign out_distance_mm = out_dist_r;
  assign out_degenerate  = out_dg_r;
  assign out_saturated   = out_sat_r;

endmodule

// ===== hdl/spld_checker.sv =====
// ----------------------------------------------------------------------------
// spld_checker
// Port-level checks for the point-line distance block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_distance_mm,
  input logic               out_degenerate,
  input logic               out_saturated
);

  logic degen_ok, on_rail;

  assign degen_ok = (out_distance_mm == 32'sd0) && !out_saturated;
  assign on_rail  = (out_distance_mm == 32'sh7FFF_FFFF) ||
                    (out_distance_mm == $signed(32'h8000_0000));

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped")
  `ASSERT_IMPL(a_degen_zero, out_valid && out_degenerate, degen_ok, "bad degenerate item")
  `ASSERT_IMPL(a_sat_rail, out_valid && out_saturated, on_rail, "saturated item off the rails")
  `ASSERT_IMPL(a_ready_empty, !out_valid, in_ready, "input held off with empty output")

endmodule

bind signed_point_line_distance spld_checker u_spld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_distance_mm (out_distance_mm),
  .out_degenerate  (out_degenerate),
  .out_saturated   (out_saturated)
);
